/* src/oet_pkg.sv */
// types and constants shared by the occupancy evidence table modules
// no dependencies
package oet_pkg;

   localparam int KEY_W = 64;
   localparam int FRAME_W = 32;
   localparam int LIVE_W = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [7:0] NO_INFO_COST = 8'hFF;

   typedef enum logic [1:0] {
      CMD_BEGIN_FRAME = 2'd0,
      CMD_OBSERVE     = 2'd1,
      CMD_END_FRAME   = 2'd2,
      CMD_QUERY       = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OCC_COST_MIN  = 2'd0,
      CSR_EV_LIMIT      = 2'd1,
      CSR_STATIC_EV_MIN = 2'd2,
      CSR_PRUNE_PERIOD  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_MOD,
      ST_PRUNE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] cell_x;
      logic signed [31:0] cell_y;
      logic [7:0]         cost;
   } req_type;

   typedef struct packed {
      logic              is_static;
      logic [7:0]        evidence_level;
      logic              dropped_full;
      logic [LIVE_W-1:0] live_entries;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  occ_cost_min;
      logic [7:0]  ev_limit;
      logic [7:0]  static_ev_min;
      logic [15:0] prune_period;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [7:0]         evidence;
      logic [FRAME_W-1:0] seen_frame;
   } entry_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } qhead_type;

endpackage

/* src/oet_front.sv */
// front end: accepts request beats into a two-entry queue for the back end
// depends on oet_pkg
module oet_front import oet_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_payload,
   output qhead_type head,
   input  logic      pop
);

   req_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       do_pop;

   always_comb begin
      req_ready = cnt_ff != 2'(QUEUE_DEPTH);
      push = req_valid && req_ready;
      head.valid = cnt_ff != 2'd0;
      head.item = slot_ff[rd_ptr_ff];
      do_pop = pop && head.valid;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_payload;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* src/oet_back.sv */
// back end: table memory, lookup scan, update, frame-end prune and response register
// depends on oet_pkg
module oet_back import oet_pkg::*; #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  qhead_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = AW + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

   entry_type mem [TABLE_ENTRIES];
   entry_type rdata_ff;
   logic      rd_vld_ff;
   logic [AW-1:0] rd_idx_ff;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic      hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [7:0] hit_ev_ff, hit_ev_in;
   logic      free_ok_ff, free_ok_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [FRAME_W-1:0] fc_ff, fc_in;
   logic      seen_ff, seen_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0] bit_ff, bit_in;
   logic [FRAME_W-1:0] cutoff_ff, cutoff_in;
   rsp_type   res_ff, res_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   logic          we;
   logic [AW-1:0] waddr;
   entry_type     wdata;
   logic          re;
   logic [AW-1:0] raddr;

   logic [KEY_W-1:0] key;
   logic       hit_now;
   logic       last_chk;
   logic       done;
   logic [8:0] ev_inc;
   logic [7:0] ev_new;
   logic [16:0] rem_sh;
   logic [16:0] rem_nx;
   logic [FRAME_W-1:0] w_ext;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
      rd_idx_ff <= raddr;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      hit_idx_ff <= hit_idx_in;
      hit_ev_ff <= hit_ev_in;
      free_idx_ff <= free_idx_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      cutoff_ff <= cutoff_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         fc_ff <= '0;
         seen_ff <= 1'b0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         rd_vld_ff <= re;
         hit_ff <= hit_in;
         free_ok_ff <= free_ok_in;
         fc_ff <= fc_in;
         seen_ff <= seen_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      ptr_in = ptr_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_ev_in = hit_ev_ff;
      free_ok_in = free_ok_ff;
      free_idx_in = free_idx_ff;
      fc_in = fc_ff;
      seen_in = seen_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      cutoff_in = cutoff_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      pop = 1'b0;
      we = 1'b0;
      waddr = ptr_ff[AW-1:0];
      wdata = '0;
      re = 1'b0;
      raddr = ptr_ff[AW-1:0];

      key = {item_ff.cell_x, item_ff.cell_y};
      hit_now = rd_vld_ff && rdata_ff.valid && (rdata_ff.key == key);
      last_chk = rd_vld_ff && (rd_idx_ff == LAST_IDX);
      done = hit_now || last_chk;
      ev_inc = {1'b0, hit_ev_ff} + 9'd1;
      ev_new = (ev_inc > {1'b0, cfg.ev_limit}) ? cfg.ev_limit : ev_inc[7:0];
      rem_sh = {rem_ff, fc_ff[bit_ff]};
      rem_nx = (rem_sh >= {1'b0, cfg.prune_period}) ?
               rem_sh - {1'b0, cfg.prune_period} : rem_sh;
      w_ext = FRAME_W'(cfg.prune_period);

      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff[AW-1:0] == LAST_IDX) begin
               ptr_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               item_in = head.item;
               ptr_in = '0;
               hit_in = 1'b0;
               free_ok_in = 1'b0;
               res_in = '0;
               case (head.item.command)
                  CMD_BEGIN_FRAME: begin
                     fc_in = fc_ff + FRAME_W'(1);
                     seen_in = 1'b1;
                     state_in = ST_FINISH;
                  end
                  CMD_END_FRAME: begin
                     if (cfg.prune_period == 16'd0) begin
                        state_in = ST_FINISH;
                     end else begin
                        rem_in = '0;
                        bit_in = 5'd31;
                        state_in = ST_MOD;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff) begin
               if (hit_now) begin
                  hit_in = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_ev_in = rdata_ff.evidence;
               end
               if (!rdata_ff.valid && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            if (done) begin
               state_in = ST_ACT;
            end else if (ptr_ff < CW'(TABLE_ENTRIES)) begin
               re = 1'b1;
               ptr_in = ptr_ff + CW'(1);
            end
         end
         ST_ACT: begin
            state_in = ST_FINISH;
            wdata.key = key;
            wdata.seen_frame = fc_ff;
            if (item_ff.command == CMD_QUERY) begin
               if (hit_ff) begin
                  res_in.evidence_level = hit_ev_ff;
                  res_in.is_static = seen_ff && (hit_ev_ff >= cfg.static_ev_min);
               end
            end else if (item_ff.cost == NO_INFO_COST) begin
               if (hit_ff) begin
                  res_in.evidence_level = hit_ev_ff;
               end
            end else if (item_ff.cost >= cfg.occ_cost_min) begin
               if (hit_ff) begin
                  we = 1'b1;
                  waddr = hit_idx_ff;
                  wdata.valid = 1'b1;
                  wdata.evidence = ev_new;
                  res_in.evidence_level = ev_new;
               end else if (free_ok_ff) begin
                  we = 1'b1;
                  waddr = free_idx_ff;
                  wdata.valid = 1'b1;
                  wdata.evidence = (cfg.ev_limit == 8'd0) ? 8'd0 : 8'd1;
                  res_in.evidence_level = wdata.evidence;
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  res_in.dropped_full = 1'b1;
               end
            end else if (hit_ff) begin
               we = 1'b1;
               waddr = hit_idx_ff;
               if (hit_ev_ff <= 8'd1) begin
                  wdata.valid = 1'b0;
                  cnt_in = cnt_ff - CW'(1);
               end else begin
                  wdata.valid = 1'b1;
                  wdata.evidence = hit_ev_ff - 8'd1;
                  res_in.evidence_level = hit_ev_ff - 8'd1;
               end
            end
         end
         ST_MOD: begin
            rem_in = rem_nx[15:0];
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               if (rem_nx == 17'd0) begin
                  cutoff_in = (fc_ff > w_ext) ? fc_ff - w_ext : '0;
                  ptr_in = '0;
                  state_in = ST_PRUNE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PRUNE: begin
            if (rd_vld_ff && rdata_ff.valid && (rdata_ff.seen_frame < cutoff_ff)) begin
               we = 1'b1;
               waddr = rd_idx_ff;
               wdata = rdata_ff;
               wdata.valid = 1'b0;
               cnt_in = cnt_ff - CW'(1);
            end
            if (last_chk) begin
               state_in = ST_FINISH;
            end else if (ptr_ff < CW'(TABLE_ENTRIES)) begin
               re = 1'b1;
               ptr_in = ptr_ff + CW'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = res_ff;
               rsp_in.live_entries = LIVE_W'(cnt_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_ENTRIES))
      else $error("live count above table size");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("queue popped outside idle");

   a_act_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACT) |=> (state_ff == ST_FINISH))
      else $error("update did not finish");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !we)
      else $error("table written while idle");

endmodule

/* src/occupancy_evidence_table_top.sv */
// Occupancy evidence table. Requests (begin frame, observe, end frame, query) enter on
// the req_ valid/ready channel; each beat yields exactly one rsp_ beat, in order.
// Configuration registers are written through csr_write_en/csr_index/csr_wdata; the user
// must write them only while idle, which the block itself does not enforce. After reset
// a clearing pass over all TABLE_ENTRIES entries empties the table; beats are queued
// meanwhile but not processed. Steps per beat, with a table scan of one entry per cycle:
//   begin frame: the frame counter advances, then the response is issued
//   observe, query: scan to the matching entry or the last entry, then update and respond
//   end frame: frame-modulo check unless pruning is off, plus a prune scan when due
// A two-beat queue accepts requests while the back end works, and a response register
// holds a result while the receiver stalls; the back end waits until it is taken.
// depends on oet_pkg, oet_front, oet_back
module occupancy_evidence_table_top import oet_pkg::*; #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   qhead_type head;
   logic      pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_OCC_COST_MIN:  cfg_in.occ_cost_min = csr_wdata[7:0];
            CSR_EV_LIMIT:      cfg_in.ev_limit = csr_wdata[7:0];
            CSR_STATIC_EV_MIN: cfg_in.static_ev_min = csr_wdata[7:0];
            CSR_PRUNE_PERIOD:  cfg_in.prune_period = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.occ_cost_min <= 8'd253;
         cfg_ff.ev_limit <= 8'd10;
         cfg_ff.static_ev_min <= 8'd5;
         cfg_ff.prune_period <= 16'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   oet_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   oet_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for occupancy_evidence_table_top: directed and random beats,
// a table fill to capacity and config sweeps; depends on oet_pkg and the block's RTL
module testbench;
   import oet_pkg::*;

   localparam int ENTRIES = 1024;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   occupancy_evidence_table_top #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

   // predictor state
   logic [63:0] cell_key [ENTRIES];
   logic        cell_live [ENTRIES];
   logic [7:0]  cell_evid [ENTRIES];
   logic [31:0] cell_seen [ENTRIES];
   logic [31:0] frame_num;
   logic        frame_started;
   int          live_count;
   logic [7:0]  thr_reg, cap_reg, smin_reg;
   logic [15:0] stale_reg;

   req_type pending_beats[$];
   rsp_type expected_rsp[$];
   logic [31:0] x_pool[$], y_pool[$];
   int errors, rsp_count, beat_count;
   int send_idle_pct, recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int lookup_cell(logic [63:0] k);
      for (int i = 0; i < ENTRIES; i++)
         if (cell_live[i] && cell_key[i] == k) return i;
      return -1;
   endfunction

   function automatic rsp_type predict_beat(req_type r);
      rsp_type o;
      logic [63:0] k;
      int i, e;
      logic [31:0] cutoff;
      o = '0;
      k = {r.cell_x, r.cell_y};
      case (r.command)
         CMD_BEGIN_FRAME: begin
            frame_num = frame_num + 32'd1;
            frame_started = 1'b1;
         end
         CMD_OBSERVE: begin
            i = lookup_cell(k);
            if (r.cost == NO_INFO_COST) begin
               if (i >= 0) o.evidence_level = cell_evid[i];
            end else if (r.cost >= thr_reg) begin
               if (i < 0) begin
                  for (int j = 0; j < ENTRIES; j++)
                     if (!cell_live[j]) begin
                        i = j;
                        break;
                     end
                  if (i < 0) o.dropped_full = 1'b1;
                  else begin
                     cell_live[i] = 1'b1;
                     cell_key[i] = k;
                     cell_evid[i] = 8'd0;
                     live_count++;
                  end
               end
               if (i >= 0) begin
                  e = cell_evid[i] + 1;
                  if (e > cap_reg) e = cap_reg;
                  cell_evid[i] = e[7:0];
                  cell_seen[i] = frame_num;
                  o.evidence_level = e[7:0];
               end
            end else if (i >= 0) begin
               cell_seen[i] = frame_num;
               if (cell_evid[i] <= 8'd1) begin
                  cell_live[i] = 1'b0;
                  live_count--;
               end else begin
                  cell_evid[i] = cell_evid[i] - 8'd1;
                  o.evidence_level = cell_evid[i];
               end
            end
         end
         CMD_END_FRAME: begin
            if (stale_reg != 0 && frame_num % stale_reg == 0) begin
               cutoff = (frame_num > stale_reg) ? frame_num - stale_reg : 32'd0;
               for (int j = 0; j < ENTRIES; j++)
                  if (cell_live[j] && cell_seen[j] < cutoff) begin
                     cell_live[j] = 1'b0;
                     live_count--;
                  end
            end
         end
         default: begin
            i = lookup_cell(k);
            if (i >= 0) begin
               o.evidence_level = cell_evid[i];
               o.is_static = frame_started && cell_evid[i] >= smin_reg;
            end
         end
      endcase
      o.live_entries = live_count[LIVE_W-1:0];
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else if (!req_valid || req_ready) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_beat(req_payload));
            beat_count++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response beat %p", rsp_payload);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.is_static !== want.is_static
                   || rsp_payload.evidence_level !== want.evidence_level
                   || rsp_payload.dropped_full !== want.dropped_full
                   || rsp_payload.live_entries !== want.live_entries) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at response %0d: expected %p got %p",
                              rsp_count, want, rsp_payload);
               end
            end
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_OCC_COST_MIN:  thr_reg = val[7:0];
         CSR_EV_LIMIT:      cap_reg = val[7:0];
         CSR_STATIC_EV_MIN: smin_reg = val[7:0];
         default:           stale_reg = val;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(logic [7:0] thr, logic [7:0] cap, logic [7:0] smin,
                             logic [15:0] stale);
      write_reg(CSR_OCC_COST_MIN, {8'd0, thr});
      write_reg(CSR_EV_LIMIT, {8'd0, cap});
      write_reg(CSR_STATIC_EV_MIN, {8'd0, smin});
      write_reg(CSR_PRUNE_PERIOD, stale);
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic add_beat(cmd_type c, logic [31:0] x, logic [31:0] y, logic [7:0] cost);
      req_type r;
      r.command = c;
      r.cell_x = x;
      r.cell_y = y;
      r.cost = cost;
      pending_beats.push_back(r);
   endtask

   task automatic add_random(int n);
      int pick, cmd_roll, cost_roll, t;
      logic [31:0] x, y;
      logic [7:0] cost;
      cmd_type c;
      for (int n_i = 0; n_i < n; n_i++) begin
         cmd_roll = $urandom_range(99);
         c = cmd_roll < 10 ? CMD_BEGIN_FRAME : cmd_roll < 70 ? CMD_OBSERVE :
             cmd_roll < 80 ? CMD_END_FRAME : CMD_QUERY;
         if ($urandom_range(99) < 85) begin
            pick = $urandom_range(x_pool.size() - 1);
            x = x_pool[pick];
            y = y_pool[pick];
         end else begin
            x = $urandom;
            y = $urandom;
         end
         cost_roll = $urandom_range(99);
         if (cost_roll < 10) cost = NO_INFO_COST;
         else if (cost_roll < 50) cost = 8'($urandom_range(254));
         else begin
            t = int'(thr_reg) + $urandom_range(6) - 3;
            cost = t < 0 ? 8'd0 : t > 254 ? 8'd254 : t[7:0];
         end
         add_beat(c, x, y, cost);
      end
   endtask

   initial begin
      errors = 0;
      rsp_count = 0;
      beat_count = 0;
      send_idle_pct = 23;
      recv_idle_pct = 70;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < ENTRIES; i++) cell_live[i] = 1'b0;
      frame_num = 0;
      frame_started = 1'b0;
      live_count = 0;
      thr_reg = 8'd253;
      cap_reg = 8'd10;
      smin_reg = 8'd5;
      stale_reg = 16'd50;
      x_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
      y_pool = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      for (int i = 0; i < 20; i++) begin
         x_pool.push_back($urandom_range(7) - 4);
         y_pool.push_back($urandom_range(3));
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: query and observe ahead of any frame, extremes, all commands
      add_beat(CMD_QUERY, 32'h0, 32'h0, 8'd0);
      add_beat(CMD_OBSERVE, 32'h8000_0000, 32'h7FFF_FFFF, 8'd254);
      add_beat(CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
      add_beat(CMD_OBSERVE, 32'h8000_0000, 32'h7FFF_FFFF, NO_INFO_COST);
      add_beat(CMD_BEGIN_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      for (int i = 0; i < 6; i++) add_beat(CMD_OBSERVE, 32'h7FFF_FFFF, 32'h8000_0000, 8'd253);
      add_beat(CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0);
      add_beat(CMD_OBSERVE, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0);
      add_beat(CMD_OBSERVE, 32'h8000_0000, 32'h7FFF_FFFF, 8'd252);
      add_beat(CMD_OBSERVE, 32'hFFFF_FFFF, 32'h0, 8'd10);
      add_beat(CMD_END_FRAME, 32'h0, 32'h0, 8'd0);
      add_beat(CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
      add_random(160);
      drain();

      // no threshold, cap of one, pruning off
      send_idle_pct = 70;
      recv_idle_pct = 23;
      set_config(8'd0, 8'd1, 8'd0, 16'd0);
      add_random(80);
      drain();

      // lower the cap below stored evidence after building it up
      set_config(8'd254, 8'd255, 8'd255, 16'hFFFF);
      for (int i = 0; i < 8; i++) add_beat(CMD_OBSERVE, x_pool[4], y_pool[4], 8'd254);
      add_random(60);
      drain();
      set_config(8'd100, 8'd0, 8'd2, 16'd3);
      add_beat(CMD_OBSERVE, x_pool[4], y_pool[4], 8'd200);
      add_beat(CMD_QUERY, x_pool[4], y_pool[4], 8'd0);
      add_beat(CMD_OBSERVE, x_pool[4], y_pool[4], 8'd5);
      drain();
      write_reg(CSR_EV_LIMIT, 16'd3);
      add_random(100);
      drain();

      // fill the table to capacity, overflow it, then prune everything
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(8'd0, 8'd5, 8'd1, 16'd1);
      add_beat(CMD_BEGIN_FRAME, 32'h0, 32'h0, 8'd0);
      for (int i = 0; i <= ENTRIES; i++)
         add_beat(CMD_OBSERVE, 32'h4000_0000 + i, ~i, 8'($urandom_range(254)));
      add_beat(CMD_BEGIN_FRAME, 32'h0, 32'h0, 8'd0);
      add_beat(CMD_BEGIN_FRAME, 32'h0, 32'h0, 8'd0);
      add_beat(CMD_END_FRAME, 32'h0, 32'h0, 8'd0);
      add_random(20);
      drain();

      $display("covered %0d request beats and %0d response beats over several configs,",
               beat_count, rsp_count);
      $display("including a full table with overflow and a complete prune");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
